@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An implication: when the trigger holds, the consequence must follow.
`define ASSERT_IMPLY(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// A next-cycle implication: the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cfnp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfnp_pkg
// Types and codes of the circular FIFO with negative purge.
// ----------------------------------------------------------------------------
package cfnp_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  // Operation carried by one command transaction.
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_PURGE = 2'd3
  } cfnp_op_t;

  // Status returned with every result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cfnp_status_t;

  typedef struct packed {
    cfnp_op_t                  kind;
    logic signed [DATA_W-1:0]  push_value;
  } cfnp_cmd_t;

  typedef struct packed {
    cfnp_status_t              status;
    logic signed [DATA_W-1:0]  front_value;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_full;
    logic                      is_empty;
  } cfnp_rsp_t;

endpackage

@@ rtl/core/cfnp_ram.sv @@
// ----------------------------------------------------------------------------
// cfnp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cfnp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/circular_fifo_with_negative_purge.sv @@
// ----------------------------------------------------------------------------
// circular_fifo_with_negative_purge
// Ring-buffer FIFO of signed 32-bit values with push, pop, peek and a purge
// that drops every negative entry while keeping the order of the rest.
// ----------------------------------------------------------------------------
// A command transaction is taken at a clock edge where start is high and busy
// is low. Every command yields exactly one result, shown on result for one
// cycle with done high; the receiver cannot stall it, so it must take the
// result in that cycle. A push, and any refused command, finishes in the
// cycle after it is taken. A pop or peek passes through S_FRONT, as the entry
// store is a RAM with a registered read port. A purge walks the live entries
// from the head through that same single read port and single write port,
// reading each entry (S_P_READ), then checking it and writing it back if
// kept (S_P_CHECK). The next command may be started in the cycle where done
// is high. The occupancy field carries the low five bits of the entry count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_fifo_with_negative_purge #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cfnp_pkg::cfnp_cmd_t  cmd,
  output logic                 done,
  output cfnp_pkg::cfnp_rsp_t  result
);

  import cfnp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer: idle, pop/peek read return, and the two-step purge walk.
  typedef enum logic [1:0] {
    S_IDLE,
    S_FRONT,
    S_P_READ,
    S_P_CHECK
  } state_t;

  state_t          state;
  cfnp_op_t        op_q;
  logic [AW-1:0]   head;
  logic [AW-1:0]   tail;
  logic [CW-1:0]   count;

  // Purge walk registers: read pointer, write pointer, entries left, entries kept.
  logic [AW-1:0]   rd_ptr;
  logic [AW-1:0]   wr_ptr;
  logic [CW-1:0]   remain;
  logic [CW-1:0]   kept;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic            accept;
  logic            full;
  logic            empty;
  logic            keep;
  logic [CW-1:0]   count_inc;
  logic [CW-1:0]   count_dec;
  logic [CW-1:0]   kept_next;
  logic [AW-1:0]   wr_ptr_next;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic cfnp_rsp_t make_rsp(input cfnp_status_t st,
                                         input logic [DATA_W-1:0] front,
                                         input logic [CW-1:0] cnt);
    cfnp_rsp_t r;
    r.status      = st;
    r.front_value = front;
    r.occupancy   = OCC_W'(cnt);
    r.is_full     = (cnt == CW'(DEPTH));
    r.is_empty    = (cnt == '0);
    return r;
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);

  always_comb begin
    count_inc   = count + 1'b1;
    count_dec   = count - 1'b1;
    // An entry survives the purge when its sign bit is clear.
    keep        = !ram_rdata[DATA_W-1];
    kept_next   = kept + CW'(keep);
    wr_ptr_next = keep ? next_slot(wr_ptr) : wr_ptr;

    // The read port looks at the head while idle, so a pop or peek has its
    // data in the cycle after acceptance; during a purge it follows rd_ptr.
    ram_raddr = (state == S_IDLE) ? head : rd_ptr;

    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = cmd.push_value;
    if (accept && cmd.kind == OP_PUSH && !full) begin
      ram_we = 1'b1;
    end
    if (state == S_P_CHECK && keep) begin
      // Survivors are packed toward the head; wr_ptr never passes rd_ptr.
      ram_we    = 1'b1;
      ram_waddr = wr_ptr;
      ram_wdata = ram_rdata;
    end
  end

  cfnp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q <= cmd.kind;
            case (cmd.kind)
              OP_PUSH: begin
                done <= 1'b1;
                if (full) begin
                  result <= make_rsp(ST_FULL, '0, count);
                end else begin
                  tail   <= next_slot(tail);
                  count  <= count_inc;
                  result <= make_rsp(ST_OK, '0, count_inc);
                end
              end
              OP_POP, OP_PEEK: begin
                if (empty) begin
                  done   <= 1'b1;
                  result <= make_rsp(ST_EMPTY, '0, count);
                end else begin
                  state <= S_FRONT;
                end
              end
              OP_PURGE: begin
                if (empty) begin
                  done   <= 1'b1;
                  result <= make_rsp(ST_EMPTY, '0, count);
                end else begin
                  rd_ptr <= head;
                  wr_ptr <= head;
                  remain <= count;
                  kept   <= '0;
                  state  <= S_P_READ;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_FRONT: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (op_q == OP_POP) begin
            head   <= next_slot(head);
            count  <= count_dec;
            result <= make_rsp(ST_OK, ram_rdata, count_dec);
          end else begin
            result <= make_rsp(ST_OK, ram_rdata, count);
          end
        end
        S_P_READ: begin
          state <= S_P_CHECK;
        end
        S_P_CHECK: begin
          rd_ptr <= next_slot(rd_ptr);
          if (remain == CW'(1)) begin
            // Last live entry checked: head stays, tail follows the survivors.
            count  <= kept_next;
            tail   <= wr_ptr_next;
            done   <= 1'b1;
            result <= make_rsp(ST_OK, '0, kept_next);
            state  <= S_IDLE;
          end else begin
            remain <= remain - 1'b1;
            kept   <= kept_next;
            wr_ptr <= wr_ptr_next;
            state  <= S_P_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The entry count never exceeds the depth.
  `ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "entry count exceeds depth")
  // A result can never claim to be both full and empty.
  `ASSERT_IMPLY(a_flags_excl, done, !(result.is_full && result.is_empty),
                "result flags full and empty together")
  // A push always finishes in the cycle after it is taken.
  `ASSERT_NEXT(a_push_one_cycle, accept && cmd.kind == OP_PUSH, done && !busy,
               "push result not delivered in the next cycle")
  // During the purge walk no more entries are kept than were live.
  `ASSERT_IMPLY(a_purge_kept, state == S_P_CHECK, kept < count && remain != '0,
                "purge walk kept more entries than were live")

endmodule
